// ===== hw/rtl/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg: shared definitions for the spectral freeze crossfade
// Widths, ramp constants, register indexes and the types that pass between
// the frame control, the frozen store and the mixer.
// ----------------------------------------------------------------------------
package sfc_pkg;

   localparam int NUM_BINS    = 1024;
   localparam int MAG_WIDTH   = 16;
   localparam int IDX_WIDTH   = 10;
   localparam int ADDR_WIDTH  = $clog2(NUM_BINS);
   localparam int RAMP_WIDTH  = 17;
   localparam int RATE_WIDTH  = 18;
   localparam int STEP_WIDTH  = 17;
   localparam int PROD_WIDTH  = MAG_WIDTH + RAMP_WIDTH;
   localparam int TDATA_WIDTH = ((MAG_WIDTH + IDX_WIDTH + 7) / 8) * 8;

   // Ramp is unsigned Q1.16; RAMP_ONE is 1.0 (fully live).
   localparam logic [RAMP_WIDTH-1:0] RAMP_ONE      = 17'h10000;
   localparam logic [RAMP_WIDTH-1:0] LIVE_THRESH   = 17'd65471;
   localparam logic [RAMP_WIDTH-1:0] FROZEN_THRESH = 17'd65;

   localparam logic [STEP_WIDTH-1:0] ONSET_RESET   = 17'd1311;
   localparam logic [STEP_WIDTH-1:0] RELEASE_RESET = 17'd656;

   localparam int CSR_IDX_WIDTH = 1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ONSET   = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RELEASE = 1'd1;

   typedef enum logic [1:0] {
      MODE_LIVE,
      MODE_FROZEN,
      MODE_MIX
   } mode_type;

   typedef struct packed {
      logic                  capture;
      logic [RAMP_WIDTH-1:0] ramp;
      mode_type              mode;
   } frame_ctrl_type;

endpackage

// ===== hw/rtl/sfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfc_ctrl: frame control for the spectral freeze crossfade
// Holds the step registers (csr written), the button history, the capture
// flag and the crossfade ramp, which it updates at each bin zero. Reports
// the ramp and output mode that apply to the transaction being processed.
// ----------------------------------------------------------------------------
module sfc_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [sfc_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [sfc_pkg::STEP_WIDTH-1:0]     csr_wdata,
   input  logic                               fire,
   input  logic                               frame_start,
   input  logic                               button,
   output sfc_pkg::frame_ctrl_type            ctrl
);

   logic [sfc_pkg::STEP_WIDTH-1:0] onset_ff;
   logic [sfc_pkg::STEP_WIDTH-1:0] release_ff;
   logic                           button_last_ff;
   logic                           capture_ff;
   logic [sfc_pkg::RAMP_WIDTH-1:0] ramp_ff;
   logic signed [sfc_pkg::RATE_WIDTH-1:0] rate_ff;

   logic                           rise;
   logic                           fall;
   logic [sfc_pkg::STEP_WIDTH-1:0] onset_clamped;
   logic [sfc_pkg::STEP_WIDTH-1:0] release_clamped;
   logic signed [sfc_pkg::RATE_WIDTH-1:0] rate_sel;
   logic [sfc_pkg::RAMP_WIDTH-1:0] ramp_sel;
   logic signed [sfc_pkg::RATE_WIDTH:0]   ramp_sum;
   logic [sfc_pkg::RAMP_WIDTH-1:0] ramp_in;
   logic signed [sfc_pkg::RATE_WIDTH-1:0] rate_in;
   logic [sfc_pkg::RAMP_WIDTH-1:0] ramp_now;
   sfc_pkg::mode_type              mode_now;

   assign rise = button & ~button_last_ff;
   assign fall = ~button & button_last_ff;

   // Steps above 1.0 behave as 1.0.
   assign onset_clamped   = (onset_ff > sfc_pkg::RAMP_ONE) ? sfc_pkg::RAMP_ONE : onset_ff;
   assign release_clamped = (release_ff > sfc_pkg::RAMP_ONE) ? sfc_pkg::RAMP_ONE : release_ff;

   always_comb begin
      priority if (rise) begin
         rate_sel = -$signed({1'b0, onset_clamped});
         ramp_sel = sfc_pkg::RAMP_ONE;
      end else if (fall) begin
         rate_sel = $signed({1'b0, release_clamped});
         ramp_sel = ramp_ff;
      end else begin
         rate_sel = rate_ff;
         ramp_sel = ramp_ff;
      end
      ramp_sum = $signed({2'b00, ramp_sel}) + $signed({rate_sel[sfc_pkg::RATE_WIDTH-1], rate_sel});
      ramp_in  = ramp_sel;
      rate_in  = rate_sel;
      if (rate_sel != '0) begin
         priority if (ramp_sum <= 0) begin
            ramp_in = '0;
            rate_in = '0;
         end else if (ramp_sum >= $signed({2'b00, sfc_pkg::RAMP_ONE})) begin
            ramp_in = sfc_pkg::RAMP_ONE;
            rate_in = '0;
         end else begin
            ramp_in = ramp_sum[sfc_pkg::RAMP_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         onset_ff       <= sfc_pkg::ONSET_RESET;
         release_ff     <= sfc_pkg::RELEASE_RESET;
         button_last_ff <= 1'b0;
         capture_ff     <= 1'b0;
         ramp_ff        <= sfc_pkg::RAMP_ONE;
         rate_ff        <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               sfc_pkg::CSR_ONSET:   onset_ff   <= csr_wdata;
               sfc_pkg::CSR_RELEASE: release_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (fire && frame_start) begin
            button_last_ff <= button;
            capture_ff     <= rise;
            ramp_ff        <= ramp_in;
            rate_ff        <= rate_in;
         end
      end
   end

   assign ramp_now     = frame_start ? ramp_in : ramp_ff;
   assign ctrl.capture = frame_start ? rise : capture_ff;
   assign ctrl.ramp    = ramp_now;
   assign ctrl.mode    = mode_now;

   always_comb begin
      priority if (ramp_now >= sfc_pkg::LIVE_THRESH) begin
         mode_now = sfc_pkg::MODE_LIVE;
      end else if (ramp_now <= sfc_pkg::FROZEN_THRESH) begin
         mode_now = sfc_pkg::MODE_FROZEN;
      end else begin
         mode_now = sfc_pkg::MODE_MIX;
      end
   end

endmodule

// ===== hw/rtl/sfc_store.sv =====
// ----------------------------------------------------------------------------
// sfc_store: frozen magnitude store
// One write and one registered read per cycle. After reset a clearing pass
// writes zero to every entry, one entry per cycle, and raises busy meanwhile.
// ----------------------------------------------------------------------------
module sfc_store (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic                            wr_en,
   input  logic [sfc_pkg::ADDR_WIDTH-1:0]  addr,
   input  logic [sfc_pkg::MAG_WIDTH-1:0]   wr_data,
   output logic [sfc_pkg::MAG_WIDTH-1:0]   rd_data,
   output logic                            busy
);

   logic [sfc_pkg::MAG_WIDTH-1:0]  mem [sfc_pkg::NUM_BINS];
   logic [sfc_pkg::MAG_WIDTH-1:0]  rd_ff;
   logic                           clear_ff;
   logic [sfc_pkg::ADDR_WIDTH-1:0] clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == sfc_pkg::ADDR_WIDTH'(sfc_pkg::NUM_BINS - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clear_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[addr];
      end
   end

   assign rd_data = rd_ff;
   assign busy    = clear_ff;

endmodule

// ===== hw/rtl/sfc_mix.sv =====
// ----------------------------------------------------------------------------
// sfc_mix: crossfade multiply stage
// Registers the two weighted products frozen*(1-r) and live*r, then sums
// them and picks live, frozen or the truncated mix.
// ----------------------------------------------------------------------------
module sfc_mix (
   input  logic                            clock,
   input  logic                            load,
   input  logic [sfc_pkg::MAG_WIDTH-1:0]   live,
   input  logic [sfc_pkg::MAG_WIDTH-1:0]   frozen,
   input  logic [sfc_pkg::RAMP_WIDTH-1:0]  ramp,
   input  sfc_pkg::mode_type               mode,
   input  logic [sfc_pkg::IDX_WIDTH-1:0]   idx,
   output logic [sfc_pkg::MAG_WIDTH-1:0]   mag,
   output logic [sfc_pkg::IDX_WIDTH-1:0]   mag_idx
);

   logic [sfc_pkg::PROD_WIDTH-1:0] prod_frozen_ff;
   logic [sfc_pkg::PROD_WIDTH-1:0] prod_live_ff;
   logic [sfc_pkg::MAG_WIDTH-1:0]  live_ff;
   logic [sfc_pkg::MAG_WIDTH-1:0]  frozen_ff;
   sfc_pkg::mode_type              mode_ff;
   logic [sfc_pkg::IDX_WIDTH-1:0]  idx_ff;

   logic [sfc_pkg::RAMP_WIDTH-1:0] ramp_inv;
   logic [sfc_pkg::PROD_WIDTH:0]   mix_sum;

   assign ramp_inv = sfc_pkg::RAMP_ONE - ramp;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_frozen_ff <= sfc_pkg::PROD_WIDTH'(frozen) * sfc_pkg::PROD_WIDTH'(ramp_inv);
         prod_live_ff   <= sfc_pkg::PROD_WIDTH'(live) * sfc_pkg::PROD_WIDTH'(ramp);
         live_ff        <= live;
         frozen_ff      <= frozen;
         mode_ff        <= mode;
         idx_ff         <= idx;
      end
   end

   assign mix_sum = {1'b0, prod_frozen_ff} + {1'b0, prod_live_ff};

   always_comb begin
      unique case (mode_ff)
         sfc_pkg::MODE_LIVE:   mag = live_ff;
         sfc_pkg::MODE_FROZEN: mag = frozen_ff;
         sfc_pkg::MODE_MIX:    mag = mix_sum[16 +: sfc_pkg::MAG_WIDTH];
         default:              mag = live_ff;
      endcase
   end

   assign mag_idx = idx_ff;

endmodule

// ===== hw/rtl/spectral_freeze_crossfade.sv =====
// ----------------------------------------------------------------------------
// spectral_freeze_crossfade: spectral freeze with a linear crossfade
// Streams magnitude bins, captures a frame on a freeze press and crossfades
// between live and frozen bins with a Q1.16 ramp stepped once per frame.
// ----------------------------------------------------------------------------
// The block takes one bin transaction per clock while req_tready is high and
// returns one result per bin, in order; the result is held in the output
// register until the output side is ready.
// The pipeline is an input register, a frame control and store access stage
// (the frozen store is a single memory with one registered read), a multiply
// stage and an output register; each stage moves on whenever the one after it
// is free, so bubbles close up and input is still taken while a result waits.
// After reset a clearing pass zeroes the frozen store, one entry per cycle,
// and req_tready stays low until it is done; csr writes are taken at any
// time, but should only be issued while no bin is in flight.
module spectral_freeze_crossfade (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] live_magnitude, [25:16] bin_index, [31:26] zero
   input  logic [sfc_pkg::TDATA_WIDTH-1:0]     req_tdata,
   // [0] freeze_button
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] out_magnitude, [25:16] out_index, [31:26] zero
   output logic [sfc_pkg::TDATA_WIDTH-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [sfc_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [sfc_pkg::STEP_WIDTH-1:0]      csr_wdata
);

   localparam int PAD_WIDTH = sfc_pkg::TDATA_WIDTH - sfc_pkg::MAG_WIDTH - sfc_pkg::IDX_WIDTH;

   // Input register.
   logic                              a_valid_ff;
   logic [sfc_pkg::MAG_WIDTH-1:0]     a_live_ff;
   logic [sfc_pkg::IDX_WIDTH-1:0]     a_idx_ff;
   logic                              a_button_ff;

   // Store read stage.
   logic                              b_valid_ff;
   logic [sfc_pkg::MAG_WIDTH-1:0]     b_live_ff;
   logic [sfc_pkg::IDX_WIDTH-1:0]     b_idx_ff;
   logic [sfc_pkg::RAMP_WIDTH-1:0]    b_ramp_ff;
   sfc_pkg::mode_type                 b_mode_ff;
   logic                              b_use_live_ff;
   logic                              b_use_zero_ff;

   logic                              c_valid_ff;

   // Output register.
   logic                              o_valid_ff;
   logic [sfc_pkg::MAG_WIDTH-1:0]     o_mag_ff;
   logic [sfc_pkg::IDX_WIDTH-1:0]     o_idx_ff;

   logic                              ok_out;
   logic                              ok_c;
   logic                              ok_b;
   logic                              ok_a;
   logic                              req_fire;
   logic                              a_fire;
   logic                              in_range;
   logic                              store_busy;
   logic [sfc_pkg::MAG_WIDTH-1:0]     store_rd;
   logic [sfc_pkg::MAG_WIDTH-1:0]     b_frozen;
   logic [sfc_pkg::MAG_WIDTH-1:0]     mix_mag;
   logic [sfc_pkg::IDX_WIDTH-1:0]     mix_idx;
   sfc_pkg::frame_ctrl_type           ctrl;

   assign ok_out     = ~o_valid_ff | rsp_tready;
   assign ok_c       = ~c_valid_ff | ok_out;
   assign ok_b       = ~b_valid_ff | ok_c;
   assign ok_a       = ~a_valid_ff | ok_b;
   assign req_tready = ok_a & ~store_busy;
   assign req_fire   = req_tvalid & req_tready;
   assign a_fire     = a_valid_ff & ok_b;
   assign in_range   = 32'(a_idx_ff) < 32'(sfc_pkg::NUM_BINS);

   sfc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fire        (a_fire),
      .frame_start (a_idx_ff == '0),
      .button      (a_button_ff),
      .ctrl        (ctrl)
   );

   // A bin of the capture frame is written and reads back as its own live value.
   sfc_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (ok_b),
      .wr_en   (a_fire & ctrl.capture & in_range),
      .addr    (sfc_pkg::ADDR_WIDTH'(a_idx_ff)),
      .wr_data (a_live_ff),
      .rd_data (store_rd),
      .busy    (store_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (ok_a) begin
            a_valid_ff <= req_fire;
         end
         if (ok_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (ok_c) begin
            c_valid_ff <= b_valid_ff;
         end
         if (ok_out) begin
            o_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ok_a) begin
         a_live_ff   <= req_tdata[sfc_pkg::MAG_WIDTH-1:0];
         a_idx_ff    <= req_tdata[sfc_pkg::MAG_WIDTH +: sfc_pkg::IDX_WIDTH];
         a_button_ff <= req_tuser;
      end
      if (ok_b) begin
         b_live_ff     <= a_live_ff;
         b_idx_ff      <= a_idx_ff;
         b_ramp_ff     <= ctrl.ramp;
         b_mode_ff     <= ctrl.mode;
         b_use_live_ff <= ctrl.capture & in_range;
         b_use_zero_ff <= ~in_range;
      end
      if (ok_out) begin
         o_mag_ff <= mix_mag;
         o_idx_ff <= mix_idx;
      end
   end

   always_comb begin
      priority if (b_use_live_ff) begin
         b_frozen = b_live_ff;
      end else if (b_use_zero_ff) begin
         b_frozen = '0;
      end else begin
         b_frozen = store_rd;
      end
   end

   sfc_mix u_mix (
      .clock   (clock),
      .load    (ok_c),
      .live    (b_live_ff),
      .frozen  (b_frozen),
      .ramp    (b_ramp_ff),
      .mode    (b_mode_ff),
      .idx     (b_idx_ff),
      .mag     (mix_mag),
      .mag_idx (mix_idx)
   );

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = {PAD_WIDTH'(0), o_idx_ff, o_mag_ff};

endmodule

// ===== sim/spectral_freeze_crossfade_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_freeze_crossfade_tb: self-checking bench for the freeze crossfade
// Streams frames of magnitude bins with random freeze presses under a range
// of onset and release steps, predicts every output bin and checks each
// result transaction in order against the prediction.
// ----------------------------------------------------------------------------
module spectral_freeze_crossfade_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PIPE_SETTLE = 8;
   localparam int PHASE_BINS  = 190;
   localparam int PHASE_COUNT = 8;

   typedef struct {
      logic [sfc_pkg::MAG_WIDTH-1:0] magnitude;
      logic [sfc_pkg::IDX_WIDTH-1:0] index;
   } bin_result_type;

   class freeze_scoreboard;
      logic [sfc_pkg::MAG_WIDTH-1:0]         frozen_bins [sfc_pkg::NUM_BINS];
      logic                                  button_seen;
      logic                                  capturing;
      logic [sfc_pkg::RAMP_WIDTH-1:0]        ramp_pos;
      logic signed [sfc_pkg::RATE_WIDTH-1:0] ramp_rate;
      logic [sfc_pkg::STEP_WIDTH-1:0]        onset_step;
      logic [sfc_pkg::STEP_WIDTH-1:0]        release_step;
      bin_result_type                        expected_bins [$];
      int                                    failures;

      function new();
         foreach (frozen_bins[i]) frozen_bins[i] = '0;
         button_seen  = 1'b0;
         capturing    = 1'b0;
         ramp_pos     = sfc_pkg::RAMP_ONE;
         ramp_rate    = '0;
         onset_step   = sfc_pkg::ONSET_RESET;
         release_step = sfc_pkg::RELEASE_RESET;
         failures     = 0;
      endfunction

      function void set_step(logic [sfc_pkg::CSR_IDX_WIDTH-1:0] which,
                             logic [sfc_pkg::STEP_WIDTH-1:0] value);
         if (which == sfc_pkg::CSR_ONSET) begin
            onset_step = value;
         end else begin
            release_step = value;
         end
      endfunction

      // A step above 1.0 saturates at 1.0.
      function int limit_step(logic [sfc_pkg::STEP_WIDTH-1:0] s);
         return (s > sfc_pkg::RAMP_ONE) ? int'(sfc_pkg::RAMP_ONE) : int'(s);
      endfunction

      function int pending();
         return expected_bins.size();
      endfunction

      function void note_bin(logic [sfc_pkg::MAG_WIDTH-1:0] live,
                             logic [sfc_pkg::IDX_WIDTH-1:0] idx, logic button);
         int              next_pos;
         longint unsigned fz;
         longint unsigned lv;
         longint unsigned r;
         bin_result_type  want;
         // The button only matters at bin zero, where the ramp also steps once.
         if (idx == 0) begin
            capturing = button && !button_seen;
            if (button && !button_seen) begin
               ramp_rate = sfc_pkg::RATE_WIDTH'(-limit_step(onset_step));
               ramp_pos  = sfc_pkg::RAMP_ONE;
            end else if (!button && button_seen) begin
               ramp_rate = sfc_pkg::RATE_WIDTH'(limit_step(release_step));
            end
            button_seen = button;
            if (ramp_rate != 0) begin
               next_pos = int'(ramp_pos) + int'(ramp_rate);
               if (next_pos <= 0) begin
                  ramp_pos  = '0;
                  ramp_rate = '0;
               end else if (next_pos >= int'(sfc_pkg::RAMP_ONE)) begin
                  ramp_pos  = sfc_pkg::RAMP_ONE;
                  ramp_rate = '0;
               end else begin
                  ramp_pos = sfc_pkg::RAMP_WIDTH'(next_pos);
               end
            end
         end
         if (capturing) frozen_bins[idx] = live;
         fz = 64'(frozen_bins[idx]);
         lv = 64'(live);
         r  = 64'(ramp_pos);
         if (ramp_pos >= sfc_pkg::LIVE_THRESH) begin
            want.magnitude = live;
         end else if (ramp_pos <= sfc_pkg::FROZEN_THRESH) begin
            want.magnitude = frozen_bins[idx];
         end else begin
            want.magnitude = sfc_pkg::MAG_WIDTH'((fz * (sfc_pkg::RAMP_ONE - r) + lv * r) >> 16);
         end
         want.index = idx;
         expected_bins.push_back(want);
      endfunction

      task report_mismatch(string msg);
         $display("ERROR at %0t ns: %s", $time, msg);
         failures++;
      endtask

      task check_result(logic [sfc_pkg::TDATA_WIDTH-1:0] data);
         bin_result_type                want;
         logic [sfc_pkg::MAG_WIDTH-1:0] got_mag;
         logic [sfc_pkg::IDX_WIDTH-1:0] got_idx;
         got_mag = data[sfc_pkg::MAG_WIDTH-1:0];
         got_idx = data[sfc_pkg::MAG_WIDTH+sfc_pkg::IDX_WIDTH-1:sfc_pkg::MAG_WIDTH];
         if (expected_bins.size() == 0) begin
            report_mismatch($sformatf("result with no bin outstanding: index %0d magnitude %0d",
                                      got_idx, got_mag));
         end else begin
            want = expected_bins.pop_front();
            if (got_mag !== want.magnitude)
               report_mismatch($sformatf("bin %0d magnitude: got %0d expected %0d",
                                         want.index, got_mag, want.magnitude));
            if (got_idx !== want.index)
               report_mismatch($sformatf("index: got %0d expected %0d", got_idx, want.index));
         end
      endtask
   endclass

   logic                              clock;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [sfc_pkg::TDATA_WIDTH-1:0]   req_tdata  = '0;
   logic                              req_tuser  = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b1;
   logic [sfc_pkg::TDATA_WIDTH-1:0]   rsp_tdata;
   logic                              csr_we     = 1'b0;
   logic [sfc_pkg::CSR_IDX_WIDTH-1:0] csr_index  = sfc_pkg::CSR_ONSET;
   logic [sfc_pkg::STEP_WIDTH-1:0]    csr_wdata  = '0;

   freeze_scoreboard sb;
   bit               gaps_on       = 1'b1;
   bit               ready_idle_on = 1'b1;
   int               quiet_left    = 0;
   int               cycle_count   = 0;
   logic             button_level  = 1'b0;

   spectral_freeze_crossfade uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Both transaction sides are sampled here, at the edge where they complete.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_bin(req_tdata[sfc_pkg::MAG_WIDTH-1:0],
                        req_tdata[sfc_pkg::MAG_WIDTH+sfc_pkg::IDX_WIDTH-1:sfc_pkg::MAG_WIDTH],
                        req_tuser);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
      end
   end

   // Output back-pressure: short stalls, broken up by longer quiet stretches.
   initial begin
      forever begin
         @(posedge clock);
         if (ready_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 31) == 0) begin
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   function logic [sfc_pkg::MAG_WIDTH-1:0] pick_magnitude();
      if ($urandom_range(0, 7) == 0)
         return ($urandom_range(0, 1) != 0) ? {sfc_pkg::MAG_WIDTH{1'b1}} : '0;
      return sfc_pkg::MAG_WIDTH'($urandom);
   endfunction

   task send_bin(input logic [sfc_pkg::MAG_WIDTH-1:0] mag,
                 input logic [sfc_pkg::IDX_WIDTH-1:0] idx, input logic button);
      if (gaps_on) begin
         if (quiet_left > 0) begin
            quiet_left--;
         end else if ($urandom_range(0, 31) == 0) begin
            quiet_left = $urandom_range(10, 40);
         end else if ($urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(sfc_pkg::TDATA_WIDTH-sfc_pkg::MAG_WIDTH-sfc_pkg::IDX_WIDTH){1'b0}},
                     idx, mag};
      req_tuser  <= button;
      do @(posedge clock); while (!req_tready);
   endtask

   task program_steps(input logic [sfc_pkg::STEP_WIDTH-1:0] onset,
                      input logic [sfc_pkg::STEP_WIDTH-1:0] rel);
      csr_we    <= 1'b1;
      csr_index <= sfc_pkg::CSR_ONSET;
      csr_wdata <= onset;
      @(posedge clock);
      sb.set_step(sfc_pkg::CSR_ONSET, onset);
      csr_index <= sfc_pkg::CSR_RELEASE;
      csr_wdata <= rel;
      @(posedge clock);
      sb.set_step(sfc_pkg::CSR_RELEASE, rel);
      csr_we <= 1'b0;
   endtask

   // Holds off the sender until every predicted bin has come back.
   task wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   initial begin
      int                            onset_plan [PHASE_COUNT];
      int                            release_plan [PHASE_COUNT];
      int                            frame_len;
      int                            sent_here;
      logic [sfc_pkg::IDX_WIDTH-1:0] idx;
      sb = new();
      onset_plan   = '{65536, 0, 1, 131071, 20000, 3000, 0, 65537};
      release_plan = '{65536, 1, 0, 65537, 131071, 5000, 0, 40000};
      onset_plan[6]   = $urandom_range(1, 65536);
      release_plan[6] = $urandom_range(1, 65536);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset step values.
      send_bin(16'hFFFF, 10'd0, 1'b0);
      send_bin(16'h0000, 10'd1, 1'b0);
      send_bin(16'hFFFF, 10'd1023, 1'b0);
      send_bin(16'h1234, 10'd5, 1'b1);     // button is ignored away from bin zero
      send_bin(16'hAAAA, 10'd0, 1'b1);     // press: this frame is captured
      send_bin(16'h5555, 10'd1, 1'b0);
      send_bin(16'hFFFF, 10'd2, 1'b1);
      send_bin(16'h0001, 10'd1023, 1'b0);
      send_bin(16'h0000, 10'd0, 1'b1);     // held: capture ends, ramp keeps falling
      send_bin(16'hFFFF, 10'd1, 1'b1);
      send_bin(16'h0000, 10'd1023, 1'b0);
      send_bin(16'h7FFF, 10'd3, 1'b0);     // frame continues without a bin zero
      send_bin(16'h8000, 10'd0, 1'b0);     // release: ramp heads back to live
      send_bin(16'hFFFF, 10'd2, 1'b0);
      send_bin(16'h0000, 10'd0, 1'b1);     // press again mid-release
      send_bin(16'h4321, 10'd0, 1'b1);     // second bin zero in a row is no edge
      button_level = 1'b1;
      wait_drained();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p == PHASE_COUNT - 1) begin
            gaps_on       = 1'b0;
            ready_idle_on = 1'b0;
         end
         program_steps(sfc_pkg::STEP_WIDTH'(onset_plan[p]),
                       sfc_pkg::STEP_WIDTH'(release_plan[p]));
         sent_here = 0;
         while (sent_here < PHASE_BINS) begin
            if ($urandom_range(0, 3) == 0) button_level = !button_level;
            frame_len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 64)
                                                     : $urandom_range(1, 10);
            // Now and then a frame loses its bin zero.
            if ($urandom_range(0, 11) != 0) begin
               send_bin(pick_magnitude(), '0, button_level);
               sent_here++;
            end
            for (int k = 1; k < frame_len; k++) begin
               idx = ($urandom_range(0, 9) == 0) ? sfc_pkg::IDX_WIDTH'($urandom_range(1, 1023))
                                                 : sfc_pkg::IDX_WIDTH'(k);
               send_bin(pick_magnitude(), idx, 1'($urandom_range(0, 1)));
               sent_here++;
            end
         end
         wait_drained();
      end

      repeat (PIPE_SETTLE * 2) @(posedge clock);
      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
